// ----- hw/rtl/bscf_pkg.sv -----
// shared types and constants for the bit map set, clear and find-first unit
package bscf_pkg;

    localparam int OP_W       = 3;
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int BASE_W     = 12;
    localparam int SIZE_LIMIT = 2047;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY     = 3'd0,
        OP_SET       = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_CLEAR_ALL = 3'd3,
        OP_SET_ALL   = 3'd4
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic              wr;
        logic              in_word;
        logic              bit_val;
        logic              set_hit;
        logic [BASE_W-1:0] set_pos;
        logic              clr_hit;
        logic [BASE_W-1:0] clr_pos;
    } word_res_t;

endpackage

// ----- hw/rtl/bscf_ram.sv -----
// generic simple dual-port ram with registered read
module bscf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bscf_word_unit.sv -----
// per-word update and lowest set / lowest clear search, shared over all words
module bscf_word_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         word_in,
    input  logic [bscf_pkg::BASE_W-1:0]  base,
    input  logic [bscf_pkg::SIZE_W-1:0]  size,
    input  bscf_pkg::op_t                op,
    input  logic [bscf_pkg::IDX_W-1:0]   idx,
    input  logic                         err,
    output logic [WORD_BITS-1:0]         word_out,
    output bscf_pkg::word_res_t          res
);

    localparam int PW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [bscf_pkg::BASE_W-1:0] WB_STEP = bscf_pkg::BASE_W'(WORD_BITS);

    function automatic logic [PW-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
        logic [PW-1:0] pos;
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (v[j]) begin
                pos = PW'(j);
            end
        end
        return pos;
    endfunction

    logic [bscf_pkg::BASE_W-1:0] rem;
    logic [bscf_pkg::BASE_W-1:0] idx_ext;
    logic [bscf_pkg::BASE_W-1:0] off;
    logic                        in_word;
    logic [WORD_BITS-1:0]        mask;
    logic [WORD_BITS-1:0]        onehot;
    logic [WORD_BITS-1:0]        set_vec;
    logic [WORD_BITS-1:0]        clr_vec;

    assign rem     = bscf_pkg::BASE_W'(size) - base;
    assign idx_ext = bscf_pkg::BASE_W'(idx);
    assign off     = idx_ext - base;
    assign in_word = (idx_ext >= base) && (off < WB_STEP);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j]   = bscf_pkg::BASE_W'(j) < rem;
            onehot[j] = in_word && (off == bscf_pkg::BASE_W'(j));
        end
    end

    always_comb begin
        word_out = word_in;
        if (!err) begin
            unique case (op)
                bscf_pkg::OP_SET:       word_out = word_in | onehot;
                bscf_pkg::OP_CLEAR:     word_out = word_in & ~onehot;
                bscf_pkg::OP_CLEAR_ALL: word_out = word_in & ~mask;
                bscf_pkg::OP_SET_ALL:   word_out = word_in | mask;
                default:                word_out = word_in;
            endcase
        end
    end

    assign set_vec = word_out & mask;
    assign clr_vec = ~word_out & mask;

    always_comb begin
        res.wr      = !err && ((op == bscf_pkg::OP_SET) || (op == bscf_pkg::OP_CLEAR)
                      || (op == bscf_pkg::OP_CLEAR_ALL) || (op == bscf_pkg::OP_SET_ALL));
        res.in_word = in_word;
        res.bit_val = !err && |(word_out & onehot);
        res.set_hit = |set_vec;
        res.set_pos = base + bscf_pkg::BASE_W'(lowest_one(set_vec));
        res.clr_hit = |clr_vec;
        res.clr_pos = base + bscf_pkg::BASE_W'(lowest_one(clr_vec));
    end

endmodule

// ----- hw/rtl/bitmap_set_clear_find_first_unit.sv -----
// top level: bit map with set, clear and find-first search over a word ram
//
// s_ channel takes one command word: an opcode and a bit index. after the
// operation the m_ channel returns one result word: the indexed bit, the
// lowest set and lowest clear bit below the size in use with found flags,
// and an index error flag (map left unchanged on error).
// cfg_wr_en / cfg_wr_data write the size in use; write only while idle.
// each command walks the ram words covering the size in use, one word per
// cycle through the shared word unit, updating and searching each word as it
// passes, and s_tready stays low meanwhile. s_tready returns in the same
// cycle that the result is registered, so the unit takes no new command
// until the walk for the last one is done.
// the next command can be taken while a result waits in the output register;
// when m_tready is low a finished command holds until the register frees.
// reset (aresetn low, synchronous) clears the map through per-word valid
// bits, sets the size to 1024 and drops m_tvalid; no clearing pass needed.
module bitmap_set_clear_find_first_unit #(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bscf_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // opcode[2:0], bit_index[12:3], zero fill
    input  logic [bscf_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // bit_value[0], set_found[1], lowest_set[11:2], clear_found[12],
    // lowest_clear[22:13], index_error[23]
    output logic [bscf_pkg::OUT_W-1:0]   m_tdata
);

    localparam int STORE_BITS = (MAX_BITS > bscf_pkg::SIZE_LIMIT) ?
                                bscf_pkg::SIZE_LIMIT : MAX_BITS;
    localparam int NUM_WORDS  = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [bscf_pkg::SIZE_W-1:0] SIZE_CLAMP = bscf_pkg::SIZE_W'(STORE_BITS);
    localparam logic [bscf_pkg::BASE_W-1:0] WB_STEP    = bscf_pkg::BASE_W'(WORD_BITS);

    bscf_pkg::state_t                state_reg, state_next;
    logic [bscf_pkg::SIZE_W-1:0]     cfg_reg;
    logic [bscf_pkg::SIZE_W-1:0]     eff_size;
    logic                            s_accept;
    logic                            issue;
    logic                            done;
    logic                            out_free;

    bscf_pkg::op_t                   op_reg;
    logic [bscf_pkg::IDX_W-1:0]      idx_reg;
    logic                            err_reg;
    logic [bscf_pkg::SIZE_W-1:0]     size_reg;
    logic [AW-1:0]                   addr_reg;
    logic [AW-1:0]                   proc_addr_reg;
    logic [bscf_pkg::BASE_W-1:0]     nbase_reg;
    logic [bscf_pkg::BASE_W-1:0]     base_reg;
    logic                            proc_v_reg;
    logic                            vld_q_reg;
    logic [NUM_WORDS-1:0]            valid_reg;

    logic                            sf_reg, cf_reg, bv_reg;
    logic [bscf_pkg::IDX_W-1:0]      ls_reg, lc_reg;

    logic                            m_tvalid_reg;
    logic [bscf_pkg::OUT_W-1:0]      m_tdata_reg;

    logic [WORD_BITS-1:0]            rd_data;
    logic [WORD_BITS-1:0]            word_in;
    logic [WORD_BITS-1:0]            word_out;
    logic                            wr_en;
    bscf_pkg::word_res_t             res;

    assign eff_size = (cfg_reg > SIZE_CLAMP) ? SIZE_CLAMP : cfg_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign word_in  = vld_q_reg ? rd_data : '0;
    assign wr_en    = proc_v_reg && res.wr;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bscf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bscf_pkg::ST_SCAN;
                end
            end
            bscf_pkg::ST_SCAN: begin
                if (done) begin
                    state_next = bscf_pkg::ST_IDLE;
                end
            end
            default: state_next = bscf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            bscf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            bscf_pkg::ST_SCAN: begin
                issue = nbase_reg < bscf_pkg::BASE_W'(size_reg);
                done  = !issue && !proc_v_reg && out_free;
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bscf_pkg::ST_IDLE;
            cfg_reg      <= bscf_pkg::SIZE_RESET;
            proc_v_reg   <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            proc_v_reg <= issue;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (wr_en) begin
                valid_reg[proc_addr_reg] <= 1'b1;
            end
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= bscf_pkg::op_t'(s_tdata[2:0]);
            idx_reg   <= s_tdata[12:3];
            err_reg   <= bscf_pkg::SIZE_W'(s_tdata[12:3]) >= eff_size;
            size_reg  <= eff_size;
            addr_reg  <= '0;
            nbase_reg <= '0;
            base_reg  <= '0;
            sf_reg    <= 1'b0;
            cf_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            ls_reg    <= '0;
            lc_reg    <= '0;
        end
        if (issue) begin
            addr_reg      <= addr_reg + AW'(1);
            nbase_reg     <= nbase_reg + WB_STEP;
            proc_addr_reg <= addr_reg;
            vld_q_reg     <= valid_reg[addr_reg];
        end
        if (proc_v_reg) begin
            base_reg <= base_reg + WB_STEP;
            if (res.set_hit && !sf_reg) begin
                sf_reg <= 1'b1;
                ls_reg <= res.set_pos[bscf_pkg::IDX_W-1:0];
            end
            if (res.clr_hit && !cf_reg) begin
                cf_reg <= 1'b1;
                lc_reg <= res.clr_pos[bscf_pkg::IDX_W-1:0];
            end
            if (res.in_word) begin
                bv_reg <= res.bit_val;
            end
        end
        if (done) begin
            m_tdata_reg <= {err_reg, lc_reg, cf_reg, ls_reg, sf_reg, bv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bscf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (proc_addr_reg),
        .wr_data (word_out),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    bscf_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .word_in  (word_in),
        .base     (base_reg),
        .size     (size_reg),
        .op       (op_reg),
        .idx      (idx_reg),
        .err      (err_reg),
        .word_out (word_out),
        .res      (res)
    );

    a_err_no_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> !m_tdata[0])
        else $error("index error with bit value set");

    a_found_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] && m_tdata[12] |-> m_tdata[11:2] != m_tdata[22:13])
        else $error("lowest set and lowest clear coincide");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[11:2] == '0)
        else $error("lowest set nonzero without found flag");

    a_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == bscf_pkg::ST_SCAN)
        else $error("ram write outside scan");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == bscf_pkg::ST_SCAN && !proc_v_reg)
        else $error("accepted command did not start a scan");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the bit map set, clear and find-first unit
`timescale 1ns / 100ps

module tb_top;

    localparam int OP_W   = bscf_pkg::OP_W;
    localparam int IDX_W  = bscf_pkg::IDX_W;
    localparam int SIZE_W = bscf_pkg::SIZE_W;
    localparam int IN_W   = bscf_pkg::IN_W;
    localparam int OUT_W  = bscf_pkg::OUT_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = bscf_pkg::SIZE_RESET;

    localparam logic [OP_W-1:0] OP_QUERY     = bscf_pkg::OP_QUERY;
    localparam logic [OP_W-1:0] OP_SET       = bscf_pkg::OP_SET;
    localparam logic [OP_W-1:0] OP_CLEAR     = bscf_pkg::OP_CLEAR;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = bscf_pkg::OP_CLEAR_ALL;
    localparam logic [OP_W-1:0] OP_SET_ALL   = bscf_pkg::OP_SET_ALL;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 8;
    localparam int NUM_ROWS       = 25;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    // packed in m_tdata order, msb first
    typedef struct packed {
        logic             index_error;
        logic [IDX_W-1:0] lowest_clear;
        logic             clear_found;
        logic [IDX_W-1:0] lowest_set;
        logic             set_found;
        logic             bit_value;
    } lookup_t;

    typedef enum logic [1:0] {
        ROW_SIZE,
        ROW_PRED,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SIZE_W-1:0] size;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic              bv;
        logic              sf;
        logic [IDX_W-1:0]  ls;
        logic              cf;
        logic [IDX_W-1:0]  lc;
        logic              err;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    logic [1023:0]     map_bits = '0;
    logic [SIZE_W-1:0] map_size = SIZE_RESET;
    lookup_t           expected_lookups[$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int fail_count     = 0;
    int words_sent     = 0;
    int lookups_seen   = 0;
    int error_words    = 0;
    int size_writes    = 0;

    row_t directed_rows [NUM_ROWS] = '{
        '{ROW_TYPED, 11'd0, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b1, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_SET, 10'd1023, 1'b1, 1'b1, 10'd1023, 1'b1, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_SET, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_CLEAR, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_SET_ALL, 10'd1023, 1'b1, 1'b1, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_CLEAR, 10'd512, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_SPARE_A, 10'd512, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_SPARE_B, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_SPARE_C, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_CLEAR_ALL, 10'd0, 1'b0, 1'b0, 10'd0, 1'b1, 10'd0, 1'b0},
        '{ROW_SIZE, 11'd100, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_SET, 10'd100, 1'b0, 1'b0, 10'd0, 1'b1, 10'd0, 1'b1},
        '{ROW_PRED, 11'd0, OP_SET_ALL, 10'd99, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_CLEAR_ALL, 10'd1023, 1'b0, 1'b1, 10'd0, 1'b0, 10'd0, 1'b1},
        '{ROW_SIZE, 11'd1024, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_QUERY, 10'd100, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_SIZE, 11'd0, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_SET_ALL, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b1},
        '{ROW_SIZE, 11'd2047, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_SET, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_SIZE, 11'd1, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_PRED, 11'd0, OP_CLEAR, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_TYPED, 11'd0, OP_QUERY, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b1, 10'd0, 1'b1},
        '{ROW_PRED, 11'd0, OP_SET, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_SIZE, 11'd1024, OP_QUERY, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b0}
    };

    bitmap_set_clear_find_first_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic lookup_t predict_command(input logic [OP_W-1:0] op,
                                                input logic [IDX_W-1:0] idx);
        lookup_t     r;
        int unsigned span;
        span = (map_size > 11'd1024) ? 1024 : int'(map_size);
        r = '0;
        r.index_error = (idx >= span);
        if (!r.index_error) begin
            case (op) inside
                OP_SET:   map_bits[idx] = 1'b1;
                OP_CLEAR: map_bits[idx] = 1'b0;
                OP_CLEAR_ALL, OP_SET_ALL: begin
                    for (int i = 0; i < span; i++) map_bits[i] = (op == OP_SET_ALL);
                end
                default: ;
            endcase
            r.bit_value = map_bits[idx];
        end
        for (int i = 0; i < span; i++) begin
            if (map_bits[i] && !r.set_found) begin
                r.set_found  = 1'b1;
                r.lowest_set = i[IDX_W-1:0];
            end
            if (!map_bits[i] && !r.clear_found) begin
                r.clear_found  = 1'b1;
                r.lowest_clear = i[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3) return OP_SET_ALL;
        if (r < 6) return OP_CLEAR_ALL;
        if (r < 7) return OP_SPARE_A;
        if (r < 8) return OP_SPARE_B;
        if (r < 9) return OP_SPARE_C;
        if (r < 45) return OP_SET;
        if (r < 80) return OP_CLEAR;
        return OP_QUERY;
    endfunction

    // bias toward the low end so the lowest set and clear positions keep moving
    function automatic logic [IDX_W-1:0] pick_index();
        int          r;
        int unsigned span;
        span = (map_size > 11'd1024) ? 1024 : int'(map_size);
        r = $urandom_range(99, 0);
        if (span == 0 || r < 10) return IDX_W'($urandom_range(1023, 0));
        if (r < 45) return IDX_W'($urandom_range((span < 16) ? span - 1 : 15, 0));
        if (r < 55) return IDX_W'(span - 1 - $urandom_range((span < 4) ? span - 1 : 3, 0));
        return IDX_W'($urandom_range(span - 1, 0));
    endfunction

    task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input bit typed, input lookup_t typed_want);
        lookup_t predicted;
        while ($urandom_range(99, 0) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - OP_W - IDX_W){1'b0}}, idx, op};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_command(op, idx);
        expected_lookups.push_back(typed ? typed_want : predicted);
        words_sent++;
        if (predicted.index_error) error_words++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_lookups.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        map_size = value;
        size_writes++;
    endtask

    task automatic check_lookup(input lookup_t got);
        lookup_t want;
        if (expected_lookups.size() == 0) begin
            $error("result word %h with nothing pending", got);
            fail_count++;
        end else begin
            want = expected_lookups.pop_front();
            lookups_seen++;
            if (got.bit_value !== want.bit_value) begin
                $error("bit_value expected %0d got %0d", want.bit_value, got.bit_value);
                fail_count++;
            end
            if (got.set_found !== want.set_found) begin
                $error("set_found expected %0d got %0d", want.set_found, got.set_found);
                fail_count++;
            end
            if (got.lowest_set !== want.lowest_set) begin
                $error("lowest_set expected %0d got %0d", want.lowest_set, got.lowest_set);
                fail_count++;
            end
            if (got.clear_found !== want.clear_found) begin
                $error("clear_found expected %0d got %0d", want.clear_found, got.clear_found);
                fail_count++;
            end
            if (got.lowest_clear !== want.lowest_clear) begin
                $error("lowest_clear expected %0d got %0d",
                       want.lowest_clear, got.lowest_clear);
                fail_count++;
            end
            if (got.index_error !== want.index_error) begin
                $error("index_error expected %0d got %0d", want.index_error, got.index_error);
                fail_count++;
            end
        end
    endtask

    // receiver: checks each accepted word, then picks next ready
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_lookup(m_tdata);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("watchdog: %0d cycles with no word moving, %0d results pending",
                 quiet_cycles, expected_lookups.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int          phase_sizes [NUM_PHASES];
        int          phase_items;
        logic [OP_W-1:0] op;
        lookup_t     typed_want;
        phase_sizes = '{1024, 37, 2047, 64, 1, 65, 0, 0};
        phase_sizes[NUM_PHASES-1] = $urandom_range(300, 2);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_SIZE: write_size(directed_rows[r].size);
                ROW_PRED: send_command(directed_rows[r].op, directed_rows[r].idx, 1'b0, '0);
                default: begin
                    typed_want = {directed_rows[r].err, directed_rows[r].lc,
                                  directed_rows[r].cf, directed_rows[r].ls,
                                  directed_rows[r].sf, directed_rows[r].bv};
                    send_command(directed_rows[r].op, directed_rows[r].idx, 1'b1, typed_want);
                end
            endcase
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_size(phase_sizes[ph][SIZE_W-1:0]);
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
                default: begin send_gap_pct = 8; recv_stall_pct = 8; end
            endcase
            phase_items = (phase_sizes[ph] == 0) ? 30 : 274;
            for (int n = 0; n < phase_items; n++) begin
                // long receiver hold-off fills the block, later a full drain
                if (ph == 0 && n == 60) hold_req = 1'b1;
                if (ph == 0 && n == 150) drain();
                op = pick_op();
                send_command(op, pick_index(), 1'b0, '0);
            end
        end

        drain();
        $display("sent %0d command words over %0d size settings, %0d with index error",
                 words_sent, size_writes, error_words);
        $display("checked %0d result words, %0d mismatches", lookups_seen, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
